// ----- sv/ksffp_pkg.sv -----
package ksffp_pkg;

   localparam int NAME_COUNT   = 13;
   localparam int LONGEST_NAME = 13;

   localparam int POS_W   = 4;
   localparam int FIELD_W = 4;
   localparam int LIMIT_W = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

   localparam logic [FIELD_W-1:0] UNKNOWN_FIELD = FIELD_W'(NAME_COUNT - 1);

   // Names are left-justified and padded with spaces. A space can never be
   // part of a name, so the padding also rejects bytes past a name's end.
   localparam logic [8*LONGEST_NAME-1:0] NAME_TABLE [NAME_COUNT] = '{
      "version      ",
      "ip-address   ",
      "ip-name      ",
      "tcp-port     ",
      "database-name",
      "cost         ",
      "cost-unit    ",
      "free         ",
      "maintainer   ",
      "description  ",
      "keyword-list ",
      "source       ",
      "unknown      "
   };

   localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
      4'd7, 4'd10, 4'd7, 4'd8, 4'd13, 4'd4, 4'd9, 4'd4, 4'd10, 4'd11, 4'd12, 4'd6, 4'd7
   };

endpackage

// ----- sv/ksffp_name_match.sv -----
module ksffp_name_match
   import ksffp_pkg::*;
(
   input  logic [7:0]            char_in,
   input  logic [POS_W-1:0]      position,
   input  logic [NAME_COUNT-1:0] candidates,
   output logic [NAME_COUNT-1:0] candidates_next,
   output logic [POS_W-1:0]      position_next,
   output logic [FIELD_W-1:0]    field
);

   logic [NAME_COUNT-1:0] hit;
   logic                  found;

   always_comb begin
      hit = '0;
      for (int k = 0; k < NAME_COUNT; k++) begin
         for (int j = 0; j < LONGEST_NAME; j++) begin
            if (position == POS_W'(j) &&
                NAME_TABLE[k][8*(LONGEST_NAME-1-j) +: 8] == char_in) begin
               hit[k] = 1'b1;
            end
         end
      end
      candidates_next = candidates & hit;
      position_next = (position <= POS_W'(LONGEST_NAME)) ? position + 1'b1 : position;
   end

   // The lowest surviving table entry whose length equals the bytes seen wins.
   always_comb begin
      field = UNKNOWN_FIELD;
      found = 1'b0;
      for (int k = 0; k < NAME_COUNT; k++) begin
         if (!found && candidates[k] && NAME_LEN[k] == position) begin
            field = FIELD_W'(k);
            found = 1'b1;
         end
      end
   end

endmodule

// ----- sv/keyed_source_file_field_parser.sv -----
// Parser for a parenthesized keyword/value source file, one byte per request.
// The request channel (req_*) carries the raw file bytes. The response
// channel (rsp_*) carries one response for each kept value byte, one when a
// value closes, and one when the closing parenthesis of the file is seen.
// Bytes that produce nothing (whitespace, tag names, quotes, escapes) are
// consumed without a response.
// A request is held in an input register and parsed from there, and its
// response is held in a response register. The parser takes one byte every
// cycle while the receiver does not stall; its rate is set by the single parse
// stage, which updates the parse state and the name candidate mask per byte.
// When the receiver stalls, the response register holds its response and
// the input register holds one more request; req_tready then drops.
// The csr_wr_en/csr_wr_data port sets the per-value byte limit and may be
// written only while no request is in flight.
// Synchronous reset returns the parser to waiting for the opening
// parenthesis, empties both registers, and restores the limit to 10000.
module keyed_source_file_field_parser
   import ksffp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] char_in

   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // [3:0] field_index, [11:4] value_byte,
                                           // [12] truncated, [15:13] zero
   output logic [1:0]         rsp_tuser,   // [1:0] event_kind

   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      ST_BEGIN, ST_BEFORE_TAG, ST_NAME, ST_BEFORE_VALUE, ST_PLAIN,
      ST_BRACKET, ST_QUOTED, ST_ESCAPE, ST_DONE
   } parse_state_type;

   typedef enum logic [1:0] {
      EV_BYTE  = 2'd0,
      EV_CLOSE = 2'd1,
      EV_END   = 2'd2
   } event_kind_type;

   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ESCAPE = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   parse_state_type       state_ff, state_in;
   logic [NAME_COUNT-1:0] cand_ff, cand_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [FIELD_W-1:0]    field_ff, field_in;
   logic [LIMIT_W-1:0]    vlen_ff, vlen_in;
   logic                  ovf_ff, ovf_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff, in_char_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   event_kind_type        rsp_kind_ff, rsp_kind_in;
   logic [FIELD_W-1:0]    rsp_field_ff, rsp_field_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_trunc_ff, rsp_trunc_in;

   logic                  fire;
   logic                  is_white;
   logic                  keep;
   logic                  do_close;
   logic                  do_end;
   logic                  res_valid;
   logic [LIMIT_W-1:0]    vlen_base;

   logic [NAME_COUNT-1:0] cand_next;
   logic [POS_W-1:0]      pos_next;
   logic [FIELD_W-1:0]    resolved_field;

   ksffp_name_match u_name_match (
      .char_in         (in_char_ff),
      .position        (pos_ff),
      .candidates      (cand_ff),
      .candidates_next (cand_next),
      .position_next   (pos_next),
      .field           (resolved_field)
   );

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign is_white   = in_char_ff <= CH_SPACE;

   always_comb begin
      state_in  = state_ff;
      cand_in   = cand_ff;
      pos_in    = pos_ff;
      field_in  = field_ff;
      vlen_in   = vlen_ff;
      ovf_in    = ovf_ff;
      keep      = 1'b0;
      do_close  = 1'b0;
      do_end    = 1'b0;
      vlen_base = vlen_ff;

      res_valid    = 1'b0;
      rsp_kind_in  = EV_BYTE;
      rsp_field_in = field_ff;
      rsp_byte_in  = 8'd0;
      rsp_trunc_in = 1'b0;

      if (fire) begin
         case (state_ff)
            ST_BEGIN: begin
               if (in_char_ff == CH_OPEN) begin
                  state_in = ST_BEFORE_TAG;
               end
            end
            ST_BEFORE_TAG: begin
               if (in_char_ff == CH_CLOSE) begin
                  do_end = 1'b1;
               end else if (in_char_ff == CH_COLON) begin
                  cand_in  = {NAME_COUNT{1'b1}};
                  pos_in   = '0;
                  state_in = ST_NAME;
               end
            end
            ST_NAME: begin
               if (is_white) begin
                  field_in = resolved_field;
                  state_in = ST_BEFORE_VALUE;
               end else begin
                  cand_in = cand_next;
                  pos_in  = pos_next;
               end
            end
            ST_BEFORE_VALUE: begin
               if (in_char_ff == CH_CLOSE) begin
                  do_end = 1'b1;
               end else if (!is_white) begin
                  vlen_base = '0;
                  vlen_in   = '0;
                  ovf_in    = 1'b0;
                  if (in_char_ff == CH_QUOTE) begin
                     state_in = ST_QUOTED;
                  end else begin
                     state_in = (in_char_ff == CH_OPEN) ? ST_BRACKET : ST_PLAIN;
                     keep     = 1'b1;
                  end
               end
            end
            ST_PLAIN: begin
               if (is_white) begin
                  do_close = 1'b1;
               end else begin
                  keep = 1'b1;
               end
            end
            ST_BRACKET: begin
               if (in_char_ff == CH_CLOSE) begin
                  do_close = 1'b1;
               end else begin
                  keep = 1'b1;
               end
            end
            ST_QUOTED: begin
               if (in_char_ff == CH_QUOTE) begin
                  do_close = 1'b1;
               end else if (in_char_ff == CH_ESCAPE) begin
                  state_in = ST_ESCAPE;
               end else begin
                  keep = 1'b1;
               end
            end
            ST_ESCAPE: begin
               state_in = ST_QUOTED;
               keep     = 1'b1;
            end
            ST_DONE: begin
            end
            default: begin
               state_in = ST_BEGIN;
            end
         endcase

         if (do_end) begin
            state_in     = ST_DONE;
            res_valid    = 1'b1;
            rsp_kind_in  = EV_END;
            rsp_field_in = '0;
         end

         if (do_close) begin
            state_in     = ST_BEFORE_TAG;
            res_valid    = 1'b1;
            rsp_kind_in  = EV_CLOSE;
            rsp_trunc_in = ovf_ff;
         end

         if (keep) begin
            if (vlen_base < limit_ff) begin
               vlen_in     = vlen_base + 1'b1;
               res_valid   = 1'b1;
               rsp_byte_in = in_char_ff;
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      if (fire) begin
         rsp_valid_in = res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end

      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BEGIN;
         cand_ff      <= '0;
         pos_ff       <= '0;
         field_ff     <= '0;
         vlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cand_ff      <= cand_in;
         pos_ff       <= pos_in;
         field_ff     <= field_in;
         vlen_ff      <= vlen_in;
         ovf_ff       <= ovf_in;
         limit_ff     <= limit_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff <= in_char_in;
      if (fire && res_valid) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_field_ff <= rsp_field_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_trunc_ff <= rsp_trunc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_trunc_ff, rsp_byte_ff, rsp_field_ff};

   // The end of the file is final until reset.
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_DONE)
      else $error("parser left the end-of-file state");

   // A request that cannot be parsed stays in the input register.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_char_ff)))
      else $error("pending request lost from the input register");

   // A kept value byte always counts toward the value length.
   a_byte_counted: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && rsp_kind_in == EV_BYTE) |=>
         (vlen_ff != '0 && vlen_ff <= limit_ff))
      else $error("value byte sent without being counted");

   // The name position saturates one past the longest name.
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(LONGEST_NAME + 1))
      else $error("name position beyond saturation");

endmodule

// ----- sim/keyed_source_file_field_parser_tb.sv -----
module keyed_source_file_field_parser_tb;
   import ksffp_pkg::*;

   typedef enum logic [3:0] {
      P_BEGIN, P_BEFORE_TAG, P_NAME, P_BEFORE_VALUE, P_PLAIN,
      P_BRACKET, P_QUOTED, P_ESCAPE, P_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {EV_BYTE, EV_CLOSE, EV_EOF} event_kind_type;

   typedef struct packed {
      event_kind_type     kind;
      logic [FIELD_W-1:0] field;
      logic [7:0]         data;
      logic               trunc;
   } parser_event_type;

   localparam logic [7:0] CH_OPEN      = "(";
   localparam logic [7:0] CH_CLOSE     = ")";
   localparam logic [7:0] CH_COLON     = ":";
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_FILL      = "x";

   logic               clock;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = 8'h00;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [15:0]        rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   string tag_names [NAME_COUNT] = '{
      "version", "ip-address", "ip-name", "tcp-port", "database-name",
      "cost", "cost-unit", "free", "maintainer", "description",
      "keyword-list", "source", "unknown"
   };

   parse_phase_type    parse_phase = P_BEGIN;
   logic [NAME_COUNT-1:0] name_cand = '0;
   logic [POS_W-1:0]   name_pos = '0;
   logic [FIELD_W-1:0] cur_field = '0;
   logic [LIMIT_W-1:0] kept_count = '0;
   logic [LIMIT_W-1:0] byte_limit = LIMIT_RESET;
   logic               dropped = 1'b0;

   parser_event_type predicted_events [$];

   bit calm = 1'b0;
   int ready_hold = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int events_checked = 0;
   int clipped_closes = 0;

   keyed_source_file_field_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("keyed_source_file_field_parser_tb: done, errors");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] word_byte();
      return 8'($urandom_range(33, 255));
   endfunction

   function automatic logic [7:0] space_byte();
      if ($urandom_range(0, 3) != 0) return CH_SPACE;
      return 8'($urandom_range(0, 32));
   endfunction

   function automatic void keep_value_byte(input logic [7:0] c);
      if (kept_count < byte_limit) begin
         kept_count++;
         predicted_events.push_back('{EV_BYTE, cur_field, c, 1'b0});
      end else begin
         dropped = 1'b1;
      end
   endfunction

   function automatic void close_value();
      predicted_events.push_back('{EV_CLOSE, cur_field, 8'h00, dropped});
      clipped_closes += dropped;
      parse_phase = P_BEFORE_TAG;
   endfunction

   function automatic void note_end_of_file();
      predicted_events.push_back('{EV_EOF, {FIELD_W{1'b0}}, 8'h00, 1'b0});
      parse_phase = P_DONE;
   endfunction

   function automatic void parse_byte(input logic [7:0] c);
      case (parse_phase)
         P_BEGIN: begin
            if (c == CH_OPEN) parse_phase = P_BEFORE_TAG;
         end
         P_BEFORE_TAG: begin
            if (c == CH_CLOSE) begin
               note_end_of_file();
            end else if (c == CH_COLON) begin
               name_cand = '1;
               name_pos = '0;
               parse_phase = P_NAME;
            end
         end
         P_NAME: begin
            if (c <= CH_SPACE) begin
               cur_field = UNKNOWN_FIELD;
               for (int k = NAME_COUNT - 1; k >= 0; k--) begin
                  if (name_cand[k] && tag_names[k].len() == name_pos) cur_field = FIELD_W'(k);
               end
               parse_phase = P_BEFORE_VALUE;
            end else begin
               for (int k = 0; k < NAME_COUNT; k++) begin
                  if (name_pos >= tag_names[k].len() || tag_names[k][name_pos] != c)
                     name_cand[k] = 1'b0;
               end
               if (name_pos <= LONGEST_NAME) name_pos++;
            end
         end
         P_BEFORE_VALUE: begin
            if (c == CH_CLOSE) begin
               note_end_of_file();
            end else if (c > CH_SPACE) begin
               kept_count = '0;
               dropped = 1'b0;
               if (c == CH_QUOTE) begin
                  parse_phase = P_QUOTED;
               end else begin
                  parse_phase = (c == CH_OPEN) ? P_BRACKET : P_PLAIN;
                  keep_value_byte(c);
               end
            end
         end
         P_PLAIN: begin
            if (c <= CH_SPACE) close_value();
            else keep_value_byte(c);
         end
         P_BRACKET: begin
            if (c == CH_CLOSE) close_value();
            else keep_value_byte(c);
         end
         P_QUOTED: begin
            if (c == CH_QUOTE) close_value();
            else if (c == CH_BACKSLASH) parse_phase = P_ESCAPE;
            else keep_value_byte(c);
         end
         P_ESCAPE: begin
            parse_phase = P_QUOTED;
            keep_value_byte(c);
         end
         default: ;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(c);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (predicted_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] limit);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      byte_limit = limit;
   endtask

   task automatic resync();
      while (parse_phase != P_BEFORE_TAG && parse_phase != P_DONE) begin
         case (parse_phase)
            P_BEGIN:        send_byte(CH_OPEN);
            P_BEFORE_VALUE: send_byte(CH_FILL);
            P_BRACKET:      send_byte(CH_CLOSE);
            P_QUOTED:       send_byte(CH_QUOTE);
            P_ESCAPE:       send_byte(CH_FILL);
            default:        send_byte(CH_SPACE);
         endcase
      end
   endtask

   task automatic send_noise();
      logic [7:0] c;
      repeat ($urandom_range(1, 6)) begin
         do c = any_byte(); while (c == CH_CLOSE);
         send_byte(c);
      end
   endtask

   task automatic send_entry();
      int k;
      int pick;
      int vlen;
      logic [7:0] c;
      logic [7:0] tag_q [$];
      resync();
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, NAME_COUNT - 1);
      if (pick < 8) begin
         for (int i = 0; i < tag_names[k].len(); i++) tag_q.push_back(tag_names[k][i]);
      end
      if (pick == 7) begin
         if ($urandom_range(0, 1) != 0) void'(tag_q.pop_back());
         else tag_q.push_back(word_byte());
      end
      if (pick > 7) repeat ($urandom_range(0, 16)) tag_q.push_back(word_byte());
      send_byte(CH_COLON);
      foreach (tag_q[i]) send_byte(tag_q[i]);
      send_byte(space_byte());
      if ($urandom_range(0, 3) == 0) send_byte(space_byte());
      vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      case ($urandom_range(0, 2))
         0: begin
            do c = word_byte(); while (c == CH_QUOTE || c == CH_OPEN || c == CH_CLOSE);
            send_byte(c);
            repeat (vlen) send_byte(word_byte());
            send_byte(space_byte());
         end
         1: begin
            send_byte(CH_OPEN);
            repeat (vlen) begin
               do c = any_byte(); while (c == CH_CLOSE);
               send_byte(c);
            end
            send_byte(CH_CLOSE);
         end
         default: begin
            send_byte(CH_QUOTE);
            repeat (vlen) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_byte(CH_BACKSLASH);
                  send_byte(any_byte());
               end else begin
                  do c = any_byte(); while (c == CH_QUOTE || c == CH_BACKSLASH);
                  send_byte(c);
               end
            end
            send_byte(CH_QUOTE);
         end
      endcase
   endtask

   task automatic test_preamble();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_CLOSE);
      send_byte(CH_OPEN);
      send_byte(CH_FILL);
   endtask

   task automatic test_empty_name_bracket();
      send_byte(CH_COLON);
      send_byte(CH_SPACE);
      send_byte(CH_OPEN);
      send_byte(CH_CLOSE);
   endtask

   task automatic test_quoted_escape();
      send_text(":free");
      send_byte(CH_TAB);
      send_byte(CH_QUOTE);
      send_byte(CH_BACKSLASH);
      send_byte(CH_QUOTE);
      send_byte(8'hFF);
      send_byte(CH_QUOTE);
   endtask

   task automatic test_limit_extremes();
      set_limit('0);
      send_text(":cost x ");
      set_limit(16'd1);
      send_text(":unknown ab ");
   endtask

   task automatic test_random_phases();
      logic [LIMIT_W-1:0] limits [8] = '{
         16'd65535, 16'd3, 16'd10000, 16'd1, 16'd6, 16'd2, 16'd16, 16'd4
      };
      int start;
      for (int p = 0; p < 8; p++) begin
         set_limit(limits[p]);
         calm = (p % 4 == 3);
         start = bytes_sent;
         while (bytes_sent - start < 40) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_entry();
         end
      end
      calm = 1'b0;
   endtask

   task automatic test_end_of_file();
      resync();
      if ($urandom_range(0, 1) != 0) begin
         send_byte(CH_CLOSE);
      end else begin
         send_text(":source");
         send_byte(CH_SPACE);
         send_byte(CH_CLOSE);
      end
      send_byte(CH_OPEN);
      send_byte(CH_COLON);
      repeat (6) send_byte(any_byte());
      drain();
   endtask

   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      parser_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_events.size() == 0) begin
            $error("unexpected response: kind %0d data %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = predicted_events.pop_front();
            events_checked++;
            if (rsp_tuser !== want.kind) begin
               $error("event_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[3:0] !== want.field) begin
               $error("field_index: expected %0d, got %0d", want.field, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tdata[11:4] !== want.data) begin
               $error("value_byte: expected %h, got %h", want.data, rsp_tdata[11:4]);
               error_count++;
            end
            if (rsp_tdata[12] !== want.trunc) begin
               $error("truncated: expected %0d, got %0d", want.trunc, rsp_tdata[12]);
               error_count++;
            end
            if (rsp_tdata[15:13] !== 3'b000) begin
               $error("padding: expected 0, got %0d", rsp_tdata[15:13]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_preamble();
      test_empty_name_bracket();
      test_quoted_escape();
      test_limit_extremes();
      test_random_phases();
      test_end_of_file();
      repeat (10) @(posedge clock);
      $display("Sent %0d request bytes and checked %0d responses, %0d of them truncated closes,",
               bytes_sent, events_checked, clipped_closes);
      $display("across value limits from 0 to 65535, ending with the end-of-file marker.");
      if (error_count == 0) begin
         $display("keyed_source_file_field_parser_tb: done, clean");
      end else begin
         $display("keyed_source_file_field_parser_tb: done, errors");
      end
      $finish;
   end

endmodule
